FILE: src/eq3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eq3_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int COEF_FRAC_BITS_DEF = 30;

	localparam int NUM_BANDS = 3;
	localparam int BAND_W    = 2;
	localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);

	// band history is Q24.16
	localparam int HIST_W     = 40;
	localparam int HIST_FRAC  = 16;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 12;
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

	// multiplier operand A: 24-bit signed history high part, sign-extended by one bit
	localparam int OPA_W = HIST_W - HIST_FRAC + 1;
	// band accumulator and gain sum
	localparam int ACC_W = 48;
	localparam int SUM_W = 60;
	localparam int OUT_SHIFT = HIST_FRAC + GAIN_FRAC;

	localparam int CFG_ADDR_W = 2;
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BASS_GAIN   = 2'd0,
		REG_MID_GAIN    = 2'd1,
		REG_TREBLE_GAIN = 2'd2
	} cfg_reg_t;

	// Q2.30 coefficients per band: b0, b1, b2, a1, a2
	localparam longint COEF_Q30 [NUM_BANDS][5] = '{
		'{64'sd332167, 64'sd664333, 64'sd332167, -64'sd2093407257, 64'sd1020994099},
		'{64'sd60203957, 64'sd0, -64'sd60203957, -64'sd1678769672, 64'sd622212148},
		'{64'sd715799293, -64'sd1431598587, 64'sd715799293, -64'sd1308761722,
		  64'sd480693627}
	};

	// round half up from Q2.30 to the given number of fraction bits
	function automatic longint coef_round(longint q, int frac);
		longint half;
		int     drop;
		drop = 30 - frac;
		half = (drop > 0) ? (64'sd1 <<< (drop - 1)) : 64'sd0;
		return (q + half) >>> drop;
	endfunction

	// microcode fields
	typedef enum logic [2:0] {
		OPA_X0, OPA_X1, OPA_X2, OPA_Y1HI, OPA_Y1LO, OPA_Y2HI, OPA_Y2LO
	} opa_t;

	typedef enum logic [2:0] {
		OPB_B0, OPB_B1, OPB_B2, OPB_A1, OPB_A2, OPB_GAIN
	} opb_t;

	typedef enum logic [1:0] {
		T_HOLD, T_LOAD, T_MERGE
	} top_t;

	typedef enum logic [1:0] {
		ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
	} accop_t;

	typedef enum logic {
		SH_X, SH_Y
	} shsel_t;

	typedef enum logic [1:0] {
		SEQ_NEXT, SEQ_LOOP, SEQ_DONE
	} seqop_t;

	typedef struct packed {
		opa_t   a_sel;
		opb_t   b_sel;
		top_t   t_op;
		accop_t acc_op;
		shsel_t acc_sh;
		logic   hist_upd;
		logic   sum_add;
		seqop_t seq;
	} uword_t;

	localparam uword_t UW_NOP = '{
		a_sel: OPA_X0, b_sel: OPB_B0, t_op: T_HOLD, acc_op: ACC_HOLD,
		acc_sh: SH_X, hist_upd: 1'b0, sum_add: 1'b0, seq: SEQ_NEXT
	};

	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] UC_LOOP = PC_W'(0);

	typedef struct packed {
		logic              load_x;
		logic              en;
		logic [BAND_W-1:0] band;
		uword_t            uw;
	} ctrl_t;

	typedef enum logic {
		ST_IDLE, ST_RUN
	} st_t;

endpackage

`default_nettype wire

FILE: src/eq3_ucode_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module eq3_ucode_rom (
	input  wire logic [eq3_pkg::PC_W-1:0] pc,
	output eq3_pkg::uword_t               uw
);
	import eq3_pkg::*;

	// One band pass, looped for each band, then a final output step. Products land
	// in prod, then in the term register, then in the accumulators.
	always_comb begin
		uw = UW_NOP;
		case (pc)
			PC_W'(0): begin
				uw.a_sel = OPA_X0;
				uw.b_sel = OPB_B0;
			end
			PC_W'(1): begin
				uw.a_sel = OPA_X1;
				uw.b_sel = OPB_B1;
				uw.t_op  = T_LOAD;
			end
			PC_W'(2): begin
				uw.a_sel  = OPA_X2;
				uw.b_sel  = OPB_B2;
				uw.t_op   = T_LOAD;
				uw.acc_op = ACC_LOAD;
				uw.acc_sh = SH_X;
			end
			PC_W'(3): begin
				uw.a_sel  = OPA_Y1HI;
				uw.b_sel  = OPB_A1;
				uw.t_op   = T_LOAD;
				uw.acc_op = ACC_ADD;
				uw.acc_sh = SH_X;
			end
			PC_W'(4): begin
				uw.a_sel  = OPA_Y1LO;
				uw.b_sel  = OPB_A1;
				uw.t_op   = T_LOAD;
				uw.acc_op = ACC_ADD;
				uw.acc_sh = SH_X;
			end
			PC_W'(5): begin
				uw.a_sel = OPA_Y2HI;
				uw.b_sel = OPB_A2;
				uw.t_op  = T_MERGE;
			end
			PC_W'(6): begin
				uw.a_sel  = OPA_Y2LO;
				uw.b_sel  = OPB_A2;
				uw.t_op   = T_LOAD;
				uw.acc_op = ACC_SUB;
				uw.acc_sh = SH_Y;
			end
			PC_W'(7): begin
				uw.t_op = T_MERGE;
			end
			PC_W'(8): begin
				uw.acc_op = ACC_SUB;
				uw.acc_sh = SH_Y;
			end
			PC_W'(9): begin
				uw.hist_upd = 1'b1;
			end
			PC_W'(10): begin
				uw.a_sel = OPA_Y1HI;
				uw.b_sel = OPB_GAIN;
			end
			PC_W'(11): begin
				uw.a_sel = OPA_Y1LO;
				uw.b_sel = OPB_GAIN;
				uw.t_op  = T_LOAD;
			end
			PC_W'(12): begin
				uw.t_op = T_MERGE;
			end
			PC_W'(13): begin
				uw.sum_add = 1'b1;
				uw.seq     = SEQ_LOOP;
			end
			PC_W'(14): begin
				uw.seq = SEQ_DONE;
			end
			default: begin
				uw = UW_NOP;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/eq3_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module eq3_sequencer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_axis_tvalid,
	output logic       s_axis_tready,
	output logic       m_axis_tvalid,
	input  wire logic  m_axis_tready,
	output eq3_pkg::ctrl_t ctrl
);
	import eq3_pkg::*;

	st_t               state_q, state_d;
	logic [PC_W-1:0]   pc_q;
	logic [BAND_W-1:0] band_q;
	logic              out_valid_q;
	uword_t            uw;
	logic              stall;
	logic              en;
	logic              accept;

	eq3_ucode_rom u_rom (
		.pc (pc_q),
		.uw (uw)
	);

	// the final step waits while the previous result is still held
	assign stall = (uw.seq == SEQ_DONE) && out_valid_q && !m_axis_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (!stall && uw.seq == SEQ_DONE) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		en            = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_RUN: begin
				en = !stall;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			band_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pc_q   <= '0;
				band_q <= '0;
			end else if (en) begin
				case (uw.seq)
					SEQ_NEXT: begin
						pc_q <= pc_q + PC_W'(1);
					end
					SEQ_LOOP: begin
						if (band_q == LAST_BAND) begin
							pc_q   <= pc_q + PC_W'(1);
							band_q <= '0;
						end else begin
							pc_q   <= UC_LOOP;
							band_q <= band_q + BAND_W'(1);
						end
					end
					default: begin
						pc_q <= pc_q;
					end
				endcase
			end
			if (en && uw.seq == SEQ_DONE) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		ctrl.load_x = accept;
		ctrl.en     = en;
		ctrl.band   = band_q;
		ctrl.uw     = uw;
	end

endmodule

`default_nettype wire

FILE: src/eq3_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module eq3_datapath #(
	parameter int SAMPLE_WIDTH   = eq3_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = eq3_pkg::COEF_FRAC_BITS_DEF,
	parameter int DATA_W         = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire eq3_pkg::ctrl_t                  ctrl,
	input  wire logic [DATA_W-1:0]               s_axis_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [eq3_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [eq3_pkg::GAIN_W-1:0]      cfg_wdata,
	output logic [DATA_W-1:0]                    m_axis_tdata
);
	import eq3_pkg::*;

	localparam int CW    = COEF_FRAC_BITS + 2;
	localparam int PW    = OPA_W + CW;
	localparam int TW    = PW + HIST_FRAC;
	localparam int SH_XN = COEF_FRAC_BITS - HIST_FRAC;
	localparam int SH_YN = COEF_FRAC_BITS;
	localparam int RW    = SUM_W - OUT_SHIFT;

	localparam logic signed [ACC_W-1:0] HIST_MAX =
		{{(ACC_W - HIST_W + 1){1'b0}}, {(HIST_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] HIST_MIN = ~HIST_MAX;
	localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (OUT_SHIFT - 1);
	localparam logic [RW-1:0] OUT_MAX = RW'((64'd1 << SAMPLE_WIDTH) - 64'd1);

	logic [SAMPLE_WIDTH-1:0]  x0_q, x1_q, x2_q;
	logic signed [HIST_W-1:0] y1_q [NUM_BANDS];
	logic signed [HIST_W-1:0] y2_q [NUM_BANDS];
	logic [GAIN_W-1:0]        gain_q [NUM_BANDS];

	logic signed [PW-1:0]     prod_s1;
	logic signed [TW-1:0]     t_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [DATA_W-1:0]        out_q;

	logic signed [HIST_W-1:0] y1_sel, y2_sel;
	logic signed [OPA_W-1:0]  op_a;
	logic signed [CW-1:0]     op_b;
	logic signed [ACC_W-1:0]  term;
	logic signed [HIST_W-1:0] y_sat;
	logic signed [SUM_W-1:0]  rsum;
	logic [RW-1:0]            rnd;
	logic [SAMPLE_WIDTH-1:0]  res;

	assign y1_sel = y1_q[ctrl.band];
	assign y2_sel = y2_q[ctrl.band];

	always_comb begin
		case (ctrl.uw.a_sel)
			OPA_X0:   op_a = {{(OPA_W - SAMPLE_WIDTH){1'b0}}, x0_q};
			OPA_X1:   op_a = {{(OPA_W - SAMPLE_WIDTH){1'b0}}, x1_q};
			OPA_X2:   op_a = {{(OPA_W - SAMPLE_WIDTH){1'b0}}, x2_q};
			OPA_Y1HI: op_a = {{(OPA_W - HIST_W + HIST_FRAC){y1_sel[HIST_W-1]}},
				y1_sel[HIST_W-1:HIST_FRAC]};
			OPA_Y1LO: op_a = {{(OPA_W - HIST_FRAC){1'b0}}, y1_sel[HIST_FRAC-1:0]};
			OPA_Y2HI: op_a = {{(OPA_W - HIST_W + HIST_FRAC){y2_sel[HIST_W-1]}},
				y2_sel[HIST_W-1:HIST_FRAC]};
			OPA_Y2LO: op_a = {{(OPA_W - HIST_FRAC){1'b0}}, y2_sel[HIST_FRAC-1:0]};
			default:  op_a = '0;
		endcase
	end

	// coefficient table folds to constants
	always_comb begin
		case (ctrl.uw.b_sel)
			OPB_B0:   op_b = CW'(coef_round(COEF_Q30[ctrl.band][0], COEF_FRAC_BITS));
			OPB_B1:   op_b = CW'(coef_round(COEF_Q30[ctrl.band][1], COEF_FRAC_BITS));
			OPB_B2:   op_b = CW'(coef_round(COEF_Q30[ctrl.band][2], COEF_FRAC_BITS));
			OPB_A1:   op_b = CW'(coef_round(COEF_Q30[ctrl.band][3], COEF_FRAC_BITS));
			OPB_A2:   op_b = CW'(coef_round(COEF_Q30[ctrl.band][4], COEF_FRAC_BITS));
			OPB_GAIN: op_b = {{(CW - GAIN_W){1'b0}}, gain_q[ctrl.band]};
			default:  op_b = '0;
		endcase
	end

	// floored term: x products carry 16 fewer fraction bits than history products
	always_comb begin
		case (ctrl.uw.acc_sh)
			SH_X:    term = ACC_W'(t_q >>> SH_XN);
			SH_Y:    term = ACC_W'(t_q >>> SH_YN);
			default: term = '0;
		endcase
	end

	always_comb begin
		if (acc_q > HIST_MAX) begin
			y_sat = HIST_W'(HIST_MAX);
		end else if (acc_q < HIST_MIN) begin
			y_sat = HIST_W'(HIST_MIN);
		end else begin
			y_sat = HIST_W'(acc_q);
		end
	end

	assign rsum = sum_q + RND_HALF;
	assign rnd  = rsum[SUM_W-1:OUT_SHIFT];

	always_comb begin
		if (rnd[RW-1]) begin
			res = '0;
		end else if (rnd > OUT_MAX) begin
			res = SAMPLE_WIDTH'(OUT_MAX);
		end else begin
			res = rnd[SAMPLE_WIDTH-1:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.load_x) begin
			x0_q  <= s_axis_tdata[SAMPLE_WIDTH-1:0];
			sum_q <= '0;
		end
		if (ctrl.en) begin
			prod_s1 <= op_a * op_b;
			case (ctrl.uw.t_op)
				T_LOAD:  t_q <= TW'(prod_s1);
				T_MERGE: t_q <= (t_q <<< HIST_FRAC) + TW'(prod_s1);
				default: t_q <= t_q;
			endcase
			case (ctrl.uw.acc_op)
				ACC_LOAD: acc_q <= term;
				ACC_ADD:  acc_q <= acc_q + term;
				ACC_SUB:  acc_q <= acc_q - term;
				default:  acc_q <= acc_q;
			endcase
			if (ctrl.uw.sum_add) sum_q <= sum_q + SUM_W'(t_q);
			if (ctrl.uw.seq == SEQ_DONE) out_q <= DATA_W'(res);
		end
	end

	// filter state and gains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			for (int b = 0; b < NUM_BANDS; b++) begin
				y1_q[b]   <= '0;
				y2_q[b]   <= '0;
				gain_q[b] <= GAIN_RESET;
			end
		end else begin
			if (ctrl.en && ctrl.uw.hist_upd) begin
				y2_q[ctrl.band] <= y1_sel;
				y1_q[ctrl.band] <= y_sat;
			end
			if (ctrl.en && ctrl.uw.seq == SEQ_DONE) begin
				x2_q <= x1_q;
				x1_q <= x0_q;
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_BASS_GAIN:   gain_q[0] <= cfg_wdata;
					REG_MID_GAIN:    gain_q[1] <= cfg_wdata;
					REG_TREBLE_GAIN: gain_q[2] <= cfg_wdata;
					default:         gain_q[0] <= gain_q[0];
				endcase
			end
		end
	end

	assign m_axis_tdata = out_q;

endmodule

`default_nettype wire

FILE: src/three_band_biquad_equalizer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-band equalizer: each input sample runs through a fixed 250 Hz lowpass,
// a 250 Hz to 4 kHz bandpass and a 4 kHz highpass (direct form I biquads),
// the band outputs are scaled by bass_gain, mid_gain and treble_gain
// (unsigned Q4.12, reset to unity) and summed, then rounded and clamped to an
// unsigned sample. One result per input. From the input transfer to the output
// register, an item runs a microcode program of 14 steps per band, three times
// on a single shared multiplier, plus one step for rounding. A new sample is
// taken as soon as the previous one has reached the output register; the
// output register holds its result until transferred, and the rounding step
// waits while it is still full.
// Gain registers are written through cfg_we/cfg_addr/cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce it.
module three_band_biquad_equalizer_top #(
	parameter int SAMPLE_WIDTH   = eq3_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = eq3_pkg::COEF_FRAC_BITS_DEF,
	parameter int DATA_W         = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [DATA_W-1:0]              s_axis_tdata,  // sample_in
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [DATA_W-1:0]                   m_axis_tdata,  // sample_out
	input  wire logic                           cfg_we,
	input  wire logic [eq3_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [eq3_pkg::GAIN_W-1:0]     cfg_wdata
);
	import eq3_pkg::*;

	ctrl_t ctrl;

	eq3_sequencer u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.ctrl          (ctrl)
	);

	eq3_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.DATA_W         (DATA_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.s_axis_tdata (s_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

`default_nettype wire

FILE: src/eq3_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module eq3_checker #(
	parameter int DATA_W = 16
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_axis_tvalid,
	input wire logic              s_axis_tready,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [DATA_W-1:0] m_axis_tdata
);

	// right after an input transfer the block is busy
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an input transfer");

	// a result appears exactly when the sequencer goes idle
	a_result_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result shown while still busy");

	// busy only starts with an input transfer
	a_busy_from_in: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid))
		else $error("went busy without an input transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result dropped or changed");

endmodule

bind three_band_biquad_equalizer_top eq3_checker #(.DATA_W(DATA_W)) u_eq3_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: verif/tb_three_band_biquad_equalizer_top.sv
`timescale 1ns / 1ps

module tb_three_band_biquad_equalizer_top;
	import eq3_pkg::*;

	localparam int SMP_W       = 16;
	localparam int COEF_SHIFT  = 30;
	localparam int PIPE_CYCLES = 60;
	localparam logic [SMP_W-1:0] SMP_MAX = '1;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd4096;
	localparam logic [GAIN_W-1:0] GAIN_MAX   = '1;
	// index past the last gain register, writes there must be dropped
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

	typedef logic signed [127:0] wide_t;
	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

	// lowpass, bandpass, highpass; b0 b1 b2 a1 a2 in Q2.30
	localparam longint FILT_COEF [3][5] = '{
		'{64'sd332167, 64'sd664333, 64'sd332167, -64'sd2093407257, 64'sd1020994099},
		'{64'sd60203957, 64'sd0, -64'sd60203957, -64'sd1678769672, 64'sd622212148},
		'{64'sd715799293, -64'sd1431598587, 64'sd715799293, -64'sd1308761722,
		  64'sd480693627}
	};

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [SMP_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [SMP_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [GAIN_W-1:0] cfg_wdata;

	three_band_biquad_equalizer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	// equalizer state mirror
	logic [SMP_W-1:0]         x_d1, x_d2;
	logic signed [HIST_W-1:0] y_d1 [3];
	logic signed [HIST_W-1:0] y_d2 [3];
	logic [GAIN_W-1:0]        band_gain [3];

	logic [SMP_W-1:0] pending_samples [$];

	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold_cycles;
	int err_count;
	int samples_sent;
	int samples_checked;
	int clamp_low_hits;
	int clamp_high_hits;
	int gain_writes;
	logic [SMP_W-1:0] last_sample;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("three_band_biquad_equalizer_top regression: fail");
		$finish;
	end

	function automatic wide_t coef_mul(wide_t v, longint c);
		return (v * wide_t'(c)) >>> COEF_SHIFT;
	endfunction

	function automatic wide_t sat_hist(wide_t v);
		wide_t hmax;
		wide_t hmin;
		hmax = (wide_t'(1) <<< (HIST_W - 1)) - 1;
		hmin = -(wide_t'(1) <<< (HIST_W - 1));
		if (v > hmax)
			return hmax;
		if (v < hmin)
			return hmin;
		return v;
	endfunction

	// advances the mirrored state by one sample and returns the expected output
	function automatic logic [SMP_W-1:0] equalize(logic [SMP_W-1:0] x0);
		wide_t band_y;
		wide_t mix;
		wide_t rnd;
		mix = 0;
		for (int b = 0; b < NUM_BANDS; b++) begin
			band_y = coef_mul(wide_t'(x0) * 65536, FILT_COEF[b][0])
				+ coef_mul(wide_t'(x_d1) * 65536, FILT_COEF[b][1])
				+ coef_mul(wide_t'(x_d2) * 65536, FILT_COEF[b][2])
				- coef_mul(wide_t'(y_d1[b]), FILT_COEF[b][3])
				- coef_mul(wide_t'(y_d2[b]), FILT_COEF[b][4]);
			band_y = sat_hist(band_y);
			y_d2[b] = y_d1[b];
			y_d1[b] = band_y[HIST_W-1:0];
			mix += band_y * wide_t'(band_gain[b]);
		end
		x_d2 = x_d1;
		x_d1 = x0;
		rnd = (mix + (wide_t'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
		if (rnd < 0)
			return '0;
		if (rnd > wide_t'(SMP_MAX))
			return SMP_MAX;
		return rnd[SMP_W-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		err_count++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// output side: random or held-off tready, check on every transfer
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (pending_samples.size() == 0) begin
					report_mismatch($sformatf("unexpected sample_out %0d", m_axis_tdata));
				end else begin
					if (m_axis_tdata !== pending_samples[0])
						report_mismatch($sformatf("sample_out got %0d want %0d",
							m_axis_tdata, pending_samples[0]));
					if (pending_samples[0] == '0)
						clamp_low_hits++;
					if (pending_samples[0] == SMP_MAX)
						clamp_high_hits++;
					void'(pending_samples.pop_front());
					samples_checked++;
				end
			end
			@(negedge clk);
			if (recv_hold_cycles > 0) begin
				recv_hold_cycles--;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// entered and left at a falling edge; tvalid stays high on exit
	task automatic send_sample(input logic [SMP_W-1:0] smp);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = smp;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_samples.push_back(equalize(smp));
		samples_sent++;
		last_sample = smp;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pending_samples.size() != 0)
			@(negedge clk);
	endtask

	// only called with nothing in flight
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [GAIN_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx <= REG_TREBLE_GAIN)
			band_gain[idx] = val;
		gain_writes++;
	endtask

	task automatic set_gains(input logic [GAIN_W-1:0] bass, input logic [GAIN_W-1:0] mid,
			input logic [GAIN_W-1:0] treble);
		write_reg(REG_BASS_GAIN, bass);
		write_reg(REG_MID_GAIN, mid);
		write_reg(REG_TREBLE_GAIN, treble);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return UNITY_GAIN;
			2: return GAIN_MAX;
			default: return GAIN_W'($urandom_range(0, 16384));
		endcase
	endfunction

	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 6))
			0: return SMP_W'($urandom_range(0, 255));
			1: return SMP_MAX - SMP_W'($urandom_range(0, 255));
			2: return $urandom_range(0, 1) ? SMP_MAX : '0;
			3: return last_sample;
			4: return 16'h8000 ^ SMP_W'($urandom_range(0, 1023));
			default: return SMP_W'($urandom());
		endcase
	endfunction

	// unity gains from reset: full-scale steps, square wave at Nyquist, midscale
	task automatic test_reset_extremes();
		send_sample('0);
		repeat (3) send_sample(SMP_MAX);
		repeat (2) send_sample('0);
		repeat (2) begin
			send_sample(SMP_MAX);
			send_sample('0);
		end
		send_sample(16'h8000);
		send_sample(16'h0001);
		wait_drained();
	endtask

	// output clamping both ways, spare register index, all bands muted
	task automatic test_clamp_and_registers();
		set_gains('0, '0, GAIN_MAX);
		repeat (3) begin
			send_sample(SMP_MAX);
			send_sample('0);
		end
		wait_drained();
		set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
		repeat (3) send_sample(SMP_MAX);
		wait_drained();
		write_reg(REG_SPARE, '0);
		repeat (2) send_sample(16'h4000);
		wait_drained();
		set_gains('0, '0, '0);
		repeat (2) send_sample(SMP_MAX);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int s_pct, input int r_pct, input int n);
		wait_drained();
		set_gains(pick_gain(), pick_gain(), pick_gain());
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < n; i++) begin
			// regain now and then, between bursts only
			if (i % 60 == 59) begin
				wait_drained();
				write_reg(cfg_addr_t'($urandom_range(0, 2)), pick_gain());
			end
			send_sample(pick_sample());
		end
		wait_drained();
	endtask

	// receiver stalls for a long stretch while samples keep coming
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_gains(UNITY_GAIN, pick_gain(), pick_gain());
		recv_hold_cycles = 300;
		repeat (12) send_sample(pick_sample());
		wait_drained();
	endtask

	// sender goes quiet until everything is out, then resumes
	task automatic test_input_pause();
		recv_idle_pct = 20;
		repeat (8) send_sample(pick_sample());
		wait_drained();
		repeat (8) send_sample(pick_sample());
		wait_drained();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		x_d1 = '0;
		x_d2 = '0;
		for (int b = 0; b < NUM_BANDS; b++) begin
			y_d1[b] = '0;
			y_d2[b] = '0;
			band_gain[b] = UNITY_GAIN;
		end
		recv_hold_cycles = 0;
		err_count = 0;
		samples_sent = 0;
		samples_checked = 0;
		clamp_low_hits = 0;
		clamp_high_hits = 0;
		gain_writes = 0;
		last_sample = '0;
		send_idle_pct = 34;
		recv_idle_pct = 45;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_extremes();
		test_clamp_and_registers();
		test_random_traffic(34, 45, 170);
		test_random_traffic(45, 34, 170);
		test_random_traffic(0, 0, 170);
		test_output_backpressure();
		test_input_pause();

		wait_drained();
		repeat (PIPE_CYCLES) @(posedge clk);
		$display("Sent %0d samples through %0d gain writes, checked %0d outputs.",
			samples_sent, gain_writes, samples_checked);
		$display("Outputs at the floor: %0d, at full scale: %0d, mismatches: %0d.",
			clamp_low_hits, clamp_high_hits, err_count);
		if (err_count == 0) begin
			$display("three_band_biquad_equalizer_top regression: pass");
		end else begin
			$display("three_band_biquad_equalizer_top regression: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/eq3_pkg.sv
src/eq3_ucode_rom.sv
src/eq3_sequencer.sv
src/eq3_datapath.sv
src/three_band_biquad_equalizer_top.sv
src/eq3_checker.sv
verif/tb_three_band_biquad_equalizer_top.sv
